// ----- src/rocev2_icrc_header_crc_assert.svh -----
// ----------------------------------------------------------------------------
// icrc assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ROCEV2_ICRC_HEADER_CRC_ASSERT_SVH
`define ROCEV2_ICRC_HEADER_CRC_ASSERT_SVH

`ifndef SYNTHESIS
// check on every clock edge outside reset
`define ICRC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");
// check on every clock edge, reset included
`define ICRC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");
`else
`define ICRC_ASSERT(label, clk, rst, prop)
`define ICRC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- src/icrc_pkg.sv -----
// ----------------------------------------------------------------------------
// icrc_pkg
// shared types, constants and functions of the invariant crc header pass
// ----------------------------------------------------------------------------
`default_nettype none

package icrc_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] SEED_RESET = 32'hDEBB_20E3;

  // header layout, byte offsets from the first ip byte
  localparam int unsigned BTH_LENGTH    = 12;
  localparam int unsigned BTH_RSVD_OFS  = 4;
  localparam logic [7:0]  IPV4_HDR_LEN  = 8'd20;
  localparam logic [7:0]  IPV6_HDR_LEN  = 8'd40;
  localparam logic [7:0]  UDP_HDR_LEN   = 8'd8;
  localparam logic [7:0]  UDP_CSUM_OFS  = 8'd6;
  localparam logic [7:0]  POS_MAX       = 8'd255;

  // ipv4 variant bytes
  localparam logic [7:0]  V4_TOS        = 8'd1;
  localparam logic [7:0]  V4_TTL        = 8'd8;
  localparam logic [7:0]  V4_CSUM_HI    = 8'd10;
  localparam logic [7:0]  V4_CSUM_LO    = 8'd11;
  // ipv6 variant bytes
  localparam logic [7:0]  V6_FLOW_LO    = 8'd1;
  localparam logic [7:0]  V6_FLOW_HI    = 8'd3;
  localparam logic [7:0]  V6_HOP_LIMIT  = 8'd7;
  localparam logic [7:0]  V6_PRIO_MASK  = 8'h0F;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  // config register map
  localparam int unsigned ADDR_W     = 3;
  localparam logic        REG_SEED_IDX = 1'b0;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } icrc_item_t;

  // one byte of the reflected crc-32, eight shift steps unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // force variant header fields to ones
  function automatic logic [7:0] mask_byte(input logic [7:0] b,
                                           input logic [7:0] pos,
                                           input logic       v6);
    logic [7:0] udp_base;
    logic [7:0] bth_base;
    logic [7:0] res;
    udp_base = v6 ? IPV6_HDR_LEN : IPV4_HDR_LEN;
    bth_base = udp_base + UDP_HDR_LEN;
    res = b;
    if (pos == udp_base + UDP_CSUM_OFS || pos == udp_base + UDP_CSUM_OFS + 8'd1) begin
      res = 8'hFF;
    end else if (BTH_LENGTH > BTH_RSVD_OFS && pos == bth_base + 8'(BTH_RSVD_OFS)) begin
      res = 8'hFF;
    end else if (v6) begin
      if (pos == 8'd0) begin
        res = b | V6_PRIO_MASK;
      end else if ((pos >= V6_FLOW_LO && pos <= V6_FLOW_HI) || pos == V6_HOP_LIMIT) begin
        res = 8'hFF;
      end
    end else begin
      if (pos == V4_TOS || pos == V4_TTL || pos == V4_CSUM_HI || pos == V4_CSUM_LO) begin
        res = 8'hFF;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/icrc_front.sv -----
// ----------------------------------------------------------------------------
// icrc_front
// accepts header bytes, tracks position and ip version, masks variant fields
// ----------------------------------------------------------------------------
`default_nettype none

module icrc_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,
  input  wire logic [1:0]            s_tuser,
  input  wire logic                  s_tlast,
  output logic                       push,
  output icrc_pkg::icrc_item_t       push_item,
  input  wire logic                  q_full
);
  import icrc_pkg::*;

  logic [7:0] pos;
  logic       v6;
  logic [7:0] pos_eff;
  logic       v6_eff;
  logic       accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // first byte restarts the header at position zero with a fresh version flag
  assign pos_eff = s_tuser[0] ? 8'd0 : pos;
  assign v6_eff  = s_tuser[0] ? s_tuser[1] : v6;

  assign push            = accept;
  assign push_item.data  = mask_byte(s_tdata, pos_eff, v6_eff);
  assign push_item.first = s_tuser[0];
  assign push_item.last  = s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 8'd0;
      v6  <= 1'b0;
    end else if (accept) begin
      pos <= (pos_eff == POS_MAX) ? POS_MAX : pos_eff + 8'd1;
      v6  <= v6_eff;
    end
  end

endmodule

`default_nettype wire

// ----- src/icrc_queue.sv -----
// ----------------------------------------------------------------------------
// icrc_queue
// short fifo of masked bytes between front and crc back end
// ----------------------------------------------------------------------------
`default_nettype none
`include "rocev2_icrc_header_crc_assert.svh"

module icrc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire icrc_pkg::icrc_item_t  push_item,
  output logic                       full,
  input  wire logic                  pop,
  output icrc_pkg::icrc_item_t       head,
  output logic                       empty
);
  import icrc_pkg::*;

  icrc_item_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `ICRC_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(QDEPTH))
  `ICRC_ASSERT(a_ptr_count, clk, rst, (wr_ptr - rd_ptr) == count[QPTR_W-1:0])
  `ICRC_ASSERT(a_no_overrun, clk, rst, !(push && full) && !(pop && empty))

endmodule

`default_nettype wire

// ----- src/icrc_back.sv -----
// ----------------------------------------------------------------------------
// icrc_back
// crc runs a byte per cycle unless a last byte waits; result held for receiver
// ----------------------------------------------------------------------------
`default_nettype none

module icrc_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [31:0]           seed,
  input  wire icrc_pkg::icrc_item_t  head,
  input  wire logic                  empty,
  output logic                       pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [31:0]                m_tdata
);
  import icrc_pkg::*;

  logic [31:0] crc;
  logic [31:0] crc_base;
  logic [31:0] crc_new;
  logic        emit;

  // a last byte waits until the result register is free or being taken
  assign pop      = !empty && (!head.last || !m_tvalid || m_tready);
  assign emit     = pop && head.last;
  assign crc_base = head.first ? seed : crc;
  assign crc_new  = crc_byte(crc_base, head.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= SEED_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        crc <= crc_new;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= crc_new;
    end
  end

endmodule

`default_nettype wire

// ----- src/rocev2_icrc_header_crc.sv -----
// ----------------------------------------------------------------------------
// rocev2_icrc_header_crc
// invariant crc-32 over the masked ip, udp and bth headers of a rocev2 packet
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one header byte per request, wire order from the first ip
//   byte to the last bth byte. tuser[0] marks the first byte (crc reloads
//   from the seed, position clears, tuser[1] selects ipv6), tlast marks the
//   final transport byte.
//   m_* carries one request per header: the running crc after the last
//   byte, not inverted, ready to continue over the payload.
//   the apb port holds crc_seed at byte address 0; a new seed is used from
//   the next first byte. write it only while no header is in flight.
// byte flow and result path:
//   one byte per cycle while the queue has room; the crc of a last byte
//   reaches m_* through a queue entry and then the result register (the
//   accepting edge writes the queue, a later pop steps the crc into the
//   result register). the rate is set by the 8-bit unrolled crc step.
// reset: queue empties, no result pending, crc and seed go to 0xdebb20e3,
//   position and ip version clear.
// stall: while m_tready is low a result stays put; bytes keep flowing
//   until a further last byte reaches the back end, then the four-entry
//   queue fills and s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rocev2_icrc_header_crc (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // header byte requests
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,  // [7:0] data_byte
  input  wire logic [1:0]                  s_tuser,  // [0] first_byte, [1] is_ipv6
  input  wire logic                        s_tlast,  // last_byte
  // crc result requests
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [31:0]                      m_tdata,  // [31:0] header_crc
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [icrc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import icrc_pkg::*;

  logic        reg_sel;
  logic [31:0] seed;
  logic        push;
  icrc_item_t  push_item;
  logic        q_full;
  logic        pop;
  icrc_item_t  head;
  logic        q_empty;

  // register index is the word address
  assign reg_sel = (paddr[ADDR_W-1] == REG_SEED_IDX);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? seed : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      seed <= pwdata;
    end
  end

  // front: position tracking and masking
  icrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // decoupling queue
  icrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  // back: crc engine and result register
  icrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
